@@ rtl/rsc_pkg.sv @@
`default_nettype none

package rsc_pkg;

  // fixed port widths
  localparam int unsigned SYM_PORT_W = 5;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SEL_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_ONE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_TWO       = 3'd4;

  // configuration reset values
  localparam logic [CFG_W-1:0] START_POS_RESET = 5'd0;
  localparam logic [CFG_W-1:0] NOTCH_RESET     = 5'd25;

  // request types
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_ENCIPHER = 1'b1;

  // rotor select codes
  localparam logic [SEL_W-1:0] ROTOR_ONE   = 2'd0;
  localparam logic [SEL_W-1:0] ROTOR_TWO   = 2'd1;
  localparam logic [SEL_W-1:0] ROTOR_THREE = 2'd2;

endpackage

`default_nettype wire

@@ rtl/rsc_rotor_ram.sv @@
`default_nettype none

module rsc_rotor_ram
  import rsc_pkg::*;
#(
  parameter int unsigned DEPTH = 26
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   addr_i,
  input  wire logic [SYM_PORT_W-1:0]      wdata_i,
  output logic      [SYM_PORT_W-1:0]      rdata_o
);

  logic [SYM_PORT_W-1:0] mem [DEPTH];
  logic [SYM_PORT_W-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/rsc_stepper.sv @@
`default_nettype none

module rsc_stepper
  import rsc_pkg::*;
#(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire logic                                restart_i,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0]    start_one_i,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0]    start_two_i,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0]    start_three_i,
  input  wire logic [CFG_W-1:0]                    notch_one_i,
  input  wire logic [CFG_W-1:0]                    notch_two_i,
  output logic      [$clog2(ALPHABET_SIZE)-1:0]    pos_one_o,
  output logic      [$clog2(ALPHABET_SIZE)-1:0]    pos_two_o,
  output logic      [$clog2(ALPHABET_SIZE)-1:0]    pos_three_o
);

  localparam int unsigned SYM_W = $clog2(ALPHABET_SIZE);
  localparam int unsigned CMP_W = ((SYM_W > CFG_W) ? SYM_W : CFG_W) + 1;

  logic [SYM_W-1:0] pos_one_q, pos_two_q, pos_three_q;
  logic [SYM_W-1:0] base_one, base_two, base_three;
  logic [SYM_W-1:0] pos_one_d, pos_two_d, pos_three_d;
  logic             hit_one, hit_two;

  function automatic logic [SYM_W-1:0] step_pos(input logic [SYM_W-1:0] p);
    return (p == SYM_W'(ALPHABET_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic at_notch(input logic [SYM_W-1:0] p, input logic [CFG_W-1:0] n);
    return CMP_W'(p) == CMP_W'(n);
  endfunction

  // odometer stepping from either the running or the start positions
  always_comb begin
    base_one   = restart_i ? start_one_i   : pos_one_q;
    base_two   = restart_i ? start_two_i   : pos_two_q;
    base_three = restart_i ? start_three_i : pos_three_q;
    pos_one_d  = step_pos(base_one);
    hit_one    = at_notch(pos_one_d, notch_one_i);
    pos_two_d  = hit_one ? step_pos(base_two) : base_two;
    hit_two    = hit_one && at_notch(pos_two_d, notch_two_i);
    pos_three_d = hit_two ? step_pos(base_three) : base_three;
  end

  // position registers move once per enciphered symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_one_q   <= '0;
      pos_two_q   <= '0;
      pos_three_q <= '0;
    end else if (step_i) begin
      pos_one_q   <= pos_one_d;
      pos_two_q   <= pos_two_d;
      pos_three_q <= pos_three_d;
    end
  end

  assign pos_one_o   = pos_one_d;
  assign pos_two_o   = pos_two_d;
  assign pos_three_o = pos_three_d;

endmodule

`default_nettype wire

@@ rtl/three_rotor_stepping_cipher_core.sv @@
// Three-rotor stepping cipher. One transaction is taken per clock cycle, loads and
// enciphers alike, as long as the output side does not stall a waiting result. An
// encipher transaction steps the rotor positions when accepted, and its cipher symbol
// appears on the output after the rotor one, two and three RAM reads and the output
// register: each rotor's wiring sits in its own single-port RAM with registered read,
// and the symbol visits rotor one, two and three in that order, with every stage held
// while the output stalls. Loads write their RAM in the same pipeline slot in which
// enciphers read it, so loads and enciphers take effect in transaction order.
// A load produces no result. Wiring RAMs are not cleared by reset; enciphering
// with an entry that was never loaded gives an undefined symbol. The user must write
// configuration registers only while the pipeline is empty; the block has no check.
`default_nettype none

module three_rotor_stepping_cipher_core
  import rsc_pkg::*;
#(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic                  message_start_i,
  input  wire logic [SYM_PORT_W-1:0] plain_symbol_i,
  input  wire logic [SEL_W-1:0]      rotor_select_i,
  input  wire logic [SYM_PORT_W-1:0] wiring_index_i,
  input  wire logic [SYM_PORT_W-1:0] wiring_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [SYM_PORT_W-1:0] cipher_symbol_o
);

  localparam int unsigned SYM_W = $clog2(ALPHABET_SIZE);
  localparam int unsigned CMP_W = ((SYM_W > SYM_PORT_W) ? SYM_W : SYM_PORT_W) + 1;
  localparam int unsigned TBL_N = 2 ** SYM_PORT_W;

  typedef logic [TBL_N-1:0][SYM_W-1:0] wrap_tbl_t;

  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t tbl;
    for (int i = 0; i < TBL_N; i++) begin
      tbl[i] = SYM_W'(i % ALPHABET_SIZE);
    end
    return tbl;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();

  function automatic logic [SYM_W-1:0] mod_add(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
    logic [SYM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SYM_W+1)'(ALPHABET_SIZE)) begin
      s = s - (SYM_W+1)'(ALPHABET_SIZE);
    end
    return s[SYM_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] mod_sub(input logic [SYM_W-1:0] w,
                                               input logic [SYM_W-1:0] p);
    logic [SYM_W:0] t;
    t = {1'b0, w} + (SYM_W+1)'(ALPHABET_SIZE) - {1'b0, p};
    return (w >= p) ? (w - p) : t[SYM_W-1:0];
  endfunction

  // configuration registers
  logic [CFG_W-1:0] start_one_q, start_two_q, start_three_q;
  logic [CFG_W-1:0] notch_one_q, notch_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_one_q   <= START_POS_RESET;
      start_two_q   <= START_POS_RESET;
      start_three_q <= START_POS_RESET;
      notch_one_q   <= NOTCH_RESET;
      notch_two_q   <= NOTCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_POS_ONE:   start_one_q   <= cfg_wdata_i;
        CFG_START_POS_TWO:   start_two_q   <= cfg_wdata_i;
        CFG_START_POS_THREE: start_three_q <= cfg_wdata_i;
        CFG_NOTCH_ONE:       notch_one_q   <= cfg_wdata_i;
        CFG_NOTCH_TWO:       notch_two_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register is free or being taken
  logic advance;
  logic in_accept;
  logic out_valid_q;
  logic [SYM_PORT_W-1:0] out_sym_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  // load decode
  logic             load_ok;
  logic [CMP_W-1:0] widx_ext;
  logic [SYM_W-1:0] widx;

  assign widx_ext = CMP_W'(wiring_index_i);
  assign widx     = widx_ext[SYM_W-1:0];
  assign load_ok  = (req_type_i == REQ_LOAD) && (widx_ext < CMP_W'(ALPHABET_SIZE));

  // rotor positions for the incoming symbol
  logic             enc_accept;
  logic [SYM_W-1:0] pos_one, pos_two, pos_three;

  assign enc_accept = in_accept && (req_type_i == REQ_ENCIPHER);

  rsc_stepper #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_stepper (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (enc_accept),
    .restart_i     (message_start_i),
    .start_one_i   (WRAP_TBL[start_one_q]),
    .start_two_i   (WRAP_TBL[start_two_q]),
    .start_three_i (WRAP_TBL[start_three_q]),
    .notch_one_i   (notch_one_q),
    .notch_two_i   (notch_two_q),
    .pos_one_o     (pos_one),
    .pos_two_o     (pos_two),
    .pos_three_o   (pos_three)
  );

  // stage 0: rotor one access
  logic             ram1_we;
  logic [SYM_W-1:0] ram1_addr;
  logic [SYM_PORT_W-1:0] ram1_rdata;

  assign ram1_we   = in_accept && load_ok && (rotor_select_i == ROTOR_ONE);
  assign ram1_addr = (req_type_i == REQ_LOAD) ? widx
                                              : mod_add(WRAP_TBL[plain_symbol_i], pos_one);

  rsc_rotor_ram #(
    .DEPTH(ALPHABET_SIZE)
  ) u_ram_one (
    .clk_i   (clk_i),
    .en_i    (advance),
    .we_i    (ram1_we),
    .addr_i  (ram1_addr),
    .wdata_i (wiring_value_i),
    .rdata_o (ram1_rdata)
  );

  // stage 1 registers
  logic                  s1_vld_q, s1_enc_q, s1_we2_q, s1_we3_q;
  logic [SYM_W-1:0]      s1_p1_q, s1_p2_q, s1_p3_q, s1_widx_q;
  logic [SYM_PORT_W-1:0] s1_wval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_enc_q  <= (req_type_i == REQ_ENCIPHER);
      s1_we2_q  <= load_ok && (rotor_select_i == ROTOR_TWO);
      s1_we3_q  <= load_ok && (rotor_select_i == ROTOR_THREE);
      s1_p1_q   <= pos_one;
      s1_p2_q   <= pos_two;
      s1_p3_q   <= pos_three;
      s1_widx_q <= widx;
      s1_wval_q <= wiring_value_i;
    end
  end

  // stage 1: rotor two access
  logic [SYM_W-1:0]      ram2_addr;
  logic [SYM_PORT_W-1:0] ram2_rdata;

  assign ram2_addr = s1_we2_q ? s1_widx_q
                              : mod_add(mod_sub(WRAP_TBL[ram1_rdata], s1_p1_q), s1_p2_q);

  rsc_rotor_ram #(
    .DEPTH(ALPHABET_SIZE)
  ) u_ram_two (
    .clk_i   (clk_i),
    .en_i    (advance),
    .we_i    (s1_vld_q && s1_we2_q),
    .addr_i  (ram2_addr),
    .wdata_i (s1_wval_q),
    .rdata_o (ram2_rdata)
  );

  // stage 2 registers
  logic                  s2_vld_q, s2_enc_q, s2_we3_q;
  logic [SYM_W-1:0]      s2_p2_q, s2_p3_q, s2_widx_q;
  logic [SYM_PORT_W-1:0] s2_wval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_enc_q  <= s1_enc_q;
      s2_we3_q  <= s1_we3_q;
      s2_p2_q   <= s1_p2_q;
      s2_p3_q   <= s1_p3_q;
      s2_widx_q <= s1_widx_q;
      s2_wval_q <= s1_wval_q;
    end
  end

  // stage 2: rotor three access
  logic [SYM_W-1:0]      ram3_addr;
  logic [SYM_PORT_W-1:0] ram3_rdata;

  assign ram3_addr = s2_we3_q ? s2_widx_q
                              : mod_add(mod_sub(WRAP_TBL[ram2_rdata], s2_p2_q), s2_p3_q);

  rsc_rotor_ram #(
    .DEPTH(ALPHABET_SIZE)
  ) u_ram_three (
    .clk_i   (clk_i),
    .en_i    (advance),
    .we_i    (s2_vld_q && s2_we3_q),
    .addr_i  (ram3_addr),
    .wdata_i (s2_wval_q),
    .rdata_o (ram3_rdata)
  );

  // stage 3 registers
  logic             s3_vld_q, s3_enc_q;
  logic [SYM_W-1:0] s3_p3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (advance) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_enc_q <= s2_enc_q;
      s3_p3_q  <= s2_p3_q;
    end
  end

  // output register, holds while stalled
  logic [SYM_W-1:0] x3;

  assign x3 = mod_sub(WRAP_TBL[ram3_rdata], s3_p3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_vld_q && s3_enc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sym_q <= SYM_PORT_W'(x3);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_symbol_o = out_sym_q;

endmodule

`default_nettype wire

@@ rtl/rsc_core_sva.sv @@
`default_nettype none

module rsc_core_sva
  import rsc_pkg::*;
#(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [SYM_PORT_W-1:0] cipher_symbol_o
);

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cipher_symbol_o))
    else $error("stalled result changed");

  // input side stalls only behind a stuck result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // a stuck result freezes the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stuck");

  // enciphered symbols stay inside the alphabet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ALPHABET_SIZE > 32) || (32'(cipher_symbol_o) < ALPHABET_SIZE))
    else $error("cipher symbol outside alphabet");

endmodule

bind three_rotor_stepping_cipher_core rsc_core_sva #(
  .ALPHABET_SIZE(ALPHABET_SIZE)
) u_rsc_core_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cipher_symbol_o (cipher_symbol_o)
);

`default_nettype wire
